/* hw/rtl/spq_pkg.sv */
// Shared types, codes and the key comparator for the sorted priority queue.
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int OCC_W        = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] new_major;
        logic signed [KEY_W-1:0] new_minor;
    } cell_ctl_t;

    // True when pair a sorts strictly after pair b (major first, then minor).
    function automatic logic key_gt(
        input logic signed [KEY_W-1:0] a_major,
        input logic signed [KEY_W-1:0] a_minor,
        input logic signed [KEY_W-1:0] b_major,
        input logic signed [KEY_W-1:0] b_minor
    );
        logic gt;
        gt = (a_major > b_major) || ((a_major == b_major) && (a_minor > b_minor));
        return gt;
    endfunction

endpackage

/* hw/rtl/spq_cell.sv */
// One queue slot: compares against the broadcast key and shifts with its neighbours.
module spq_cell (
    input  logic                              clk,
    input  spq_pkg::cell_ctl_t                ctl,
    input  logic                              occupied,
    input  logic                              left_take,
    input  logic signed [spq_pkg::KEY_W-1:0]  left_major,
    input  logic signed [spq_pkg::KEY_W-1:0]  left_minor,
    input  logic signed [spq_pkg::KEY_W-1:0]  right_major,
    input  logic signed [spq_pkg::KEY_W-1:0]  right_minor,
    output logic signed [spq_pkg::KEY_W-1:0]  slot_major,
    output logic signed [spq_pkg::KEY_W-1:0]  slot_minor,
    output logic                              take
);
    import spq_pkg::*;

    logic signed [KEY_W-1:0] major_reg;
    logic signed [KEY_W-1:0] minor_reg;

    // Slot is at or past the insert point: empty, or holds a larger pair.
    assign take = !occupied || key_gt(major_reg, minor_reg, ctl.new_major, ctl.new_minor);

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            if (left_take)
            begin
                major_reg <= left_major;
                minor_reg <= left_minor;
            end
            else if (take)
            begin
                major_reg <= ctl.new_major;
                minor_reg <= ctl.new_minor;
            end
        end
        else if (ctl.rem)
        begin
            major_reg <= right_major;
            minor_reg <= right_minor;
        end
    end

    assign slot_major = major_reg;
    assign slot_minor = minor_reg;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Top level of the sorted two-key priority queue built as a chain of slot cells.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  request  | in_valid, in_stall | operation, key_major, key_minor
//  result   | out_valid,out_stall| out_major, out_minor, status, occupancy
//
// One request per cycle while in_stall is low: every cell compares the new pair
// with its own slot at once and shifts in one step, so a result is registered in
// the cycle after acceptance and the next request can enter in that same cycle.
// The result register is the only holding stage: in_stall is high while a
// result waits and out_stall is high.
// Reset clears the fill count and the result valid; slot contents are left
// as they are, since only slots below the fill count are ever read.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic signed [spq_pkg::KEY_W-1:0]  key_major,
    input  logic signed [spq_pkg::KEY_W-1:0]  key_minor,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [spq_pkg::KEY_W-1:0]  out_major,
    output logic signed [spq_pkg::KEY_W-1:0]  out_minor,
    output logic [1:0]                        status,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_major_reg;
    logic signed [KEY_W-1:0] out_minor_reg;
    status_t                 status_reg;
    logic [OCC_W-1:0]        occupancy_reg;

    logic      in_fire;
    logic      is_full;
    logic      is_empty;
    logic      do_ins;
    logic      do_rem;
    cell_ctl_t ctl;
    status_t   status_now;

    logic signed [KEY_W-1:0] slot_major_w [CAPACITY];
    logic signed [KEY_W-1:0] slot_minor_w [CAPACITY];
    logic                    take_w       [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign do_ins   = in_fire && (operation == OP_INSERT) && !is_full;
    assign do_rem   = in_fire && (operation == OP_REMOVE) && !is_empty;

    always_comb
    begin
        ctl.ins       = do_ins;
        ctl.rem       = do_rem;
        ctl.new_major = key_major;
        ctl.new_minor = key_minor;
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_rem)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        status_now = ST_DONE;
        if (operation == OP_INSERT && is_full)
            status_now = ST_FULL;
        else if (operation == OP_REMOVE && is_empty)
            status_now = ST_EMPTY;
    end

    // Slot chain: cell 0 is the front (smallest pair).
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    occ;
        logic                    l_take;
        logic signed [KEY_W-1:0] l_major;
        logic signed [KEY_W-1:0] l_minor;
        logic signed [KEY_W-1:0] r_major;
        logic signed [KEY_W-1:0] r_minor;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign l_take  = 1'b0;
            assign l_major = '0;
            assign l_minor = '0;
        end
        else
        begin : g_mid_l
            assign l_take  = take_w[i-1];
            assign l_major = slot_major_w[i-1];
            assign l_minor = slot_minor_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_major = slot_major_w[i];
            assign r_minor = slot_minor_w[i];
        end
        else
        begin : g_mid_r
            assign r_major = slot_major_w[i+1];
            assign r_minor = slot_minor_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occ),
            .left_take   (l_take),
            .left_major  (l_major),
            .left_minor  (l_minor),
            .right_major (r_major),
            .right_minor (r_minor),
            .slot_major  (slot_major_w[i]),
            .slot_minor  (slot_minor_w[i]),
            .take        (take_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded only on an accepted request.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_major_reg <= do_rem ? slot_major_w[0] : '0;
            out_minor_reg <= do_rem ? slot_minor_w[0] : '0;
            status_reg    <= status_now;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_major = out_major_reg;
    assign out_minor = out_minor_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    // Fill count never passes capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // Front two slots stay in order whenever both are held.
    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |->
            !key_gt(slot_major_w[0], slot_minor_w[0], slot_major_w[1], slot_minor_w[1]))
        else $error("front slots out of order");

    // An accepted request always leaves a result behind.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted request lost its result");

    // An empty remove reports zero occupancy and zero keys.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY) |->
            (occupancy_reg == '0 && out_major_reg == '0 && out_minor_reg == '0))
        else $error("empty remove result malformed");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the sorted two-key priority queue: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

    import spq_pkg::*;

    localparam int CAP         = SPQ_CAPACITY;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_TAIL  = 4;   // result register is one stage deep
    localparam int REPORT_MAX  = 10;

    // One expected result, field for field as the block presents it.
    typedef struct {
        logic signed [KEY_W-1:0] pair_major;
        logic signed [KEY_W-1:0] pair_minor;
        status_t                 st;
        logic [OCC_W-1:0]        occ;
    } queue_result_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    logic                    operation  = OP_INSERT;
    logic signed [KEY_W-1:0] key_major  = '0;
    logic signed [KEY_W-1:0] key_minor  = '0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic signed [KEY_W-1:0] out_major;
    logic signed [KEY_W-1:0] out_minor;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;

    // Shadow copy of the queue contents, kept sorted as the block should keep them.
    logic signed [KEY_W-1:0] shadow_major [CAP];
    logic signed [KEY_W-1:0] shadow_minor [CAP];
    int                      shadow_fill = 0;

    queue_result_t           pending_results [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int n_checked      = 0;
    int n_inserts      = 0;
    int n_removes      = 0;
    int n_full_drops   = 0;
    int n_empty_rems   = 0;

    sorted_priority_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .key_major (key_major),
        .key_minor (key_minor),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_major (out_major),
        .out_minor (out_minor),
        .status    (status),
        .occupancy (occupancy)
    );

    always #5 clk = ~clk;

    // Hard stop: a hung handshake or a lost result ends up here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure, one decision per falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Signed lexicographic "a <= b": major key decides, minor key breaks a tie.
    function automatic logic pair_le(
        input logic signed [KEY_W-1:0] a_major,
        input logic signed [KEY_W-1:0] a_minor,
        input logic signed [KEY_W-1:0] b_major,
        input logic signed [KEY_W-1:0] b_minor
    );
        return (a_major < b_major) || ((a_major == b_major) && (a_minor <= b_minor));
    endfunction

    // Applies one request to the shadow queue and returns what the block should report.
    // An insert lands after every stored pair that is <= it, so equal pairs keep
    // arrival order; a remove pops slot 0 and shifts the rest forward.
    function automatic queue_result_t shadow_queue_step(
        input logic                    op,
        input logic signed [KEY_W-1:0] new_major,
        input logic signed [KEY_W-1:0] new_minor
    );
        queue_result_t r;
        int            pos;
        int            i;
        r.pair_major = '0;
        r.pair_minor = '0;
        r.st         = ST_DONE;
        if (op == OP_INSERT)
        begin
            if (shadow_fill >= CAP)
                r.st = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < shadow_fill &&
                       pair_le(shadow_major[pos], shadow_minor[pos], new_major, new_minor))
                    pos++;
                for (i = shadow_fill; i > pos; i--)
                begin
                    shadow_major[i] = shadow_major[i-1];
                    shadow_minor[i] = shadow_minor[i-1];
                end
                shadow_major[pos] = new_major;
                shadow_minor[pos] = new_minor;
                shadow_fill++;
            end
        end
        else
        begin
            if (shadow_fill == 0)
                r.st = ST_EMPTY;
            else
            begin
                r.pair_major = shadow_major[0];
                r.pair_minor = shadow_minor[0];
                for (i = 1; i < shadow_fill; i++)
                begin
                    shadow_major[i-1] = shadow_major[i];
                    shadow_minor[i-1] = shadow_minor[i];
                end
                shadow_fill--;
            end
        end
        r.occ = OCC_W'(shadow_fill);
        return r;
    endfunction

    // Result checker: every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result maj=%0d min=%0d st=%0d occ=%0d",
                             $realtime, out_major, out_minor, status, occupancy);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_major !== want.pair_major || out_minor !== want.pair_minor ||
                    status !== want.st || occupancy !== want.occ)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: mismatch exp maj=%0d min=%0d st=%0d occ=%0d | got maj=%0d min=%0d st=%0d occ=%0d",
                                 $realtime, want.pair_major, want.pair_minor, want.st,
                                 want.occ, out_major, out_minor, status, occupancy);
                end
            end
        end
    end

    // Sends one request. Entered and left at a falling edge; valid is only ever
    // raised here and lowered either here (sender gap) or by hold_until_drained.
    task automatic send_request(
        input logic                    op,
        input logic signed [KEY_W-1:0] maj,
        input logic signed [KEY_W-1:0] mnr
    );
        queue_result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key_major <= maj;
        key_minor <= mnr;
        do
            @(posedge clk);
        while (in_stall);
        // Accepted at this edge: predict now.
        r = shadow_queue_step(op, maj, mnr);
        pending_results.push_back(r);
        if (op == OP_INSERT) n_inserts++;
        else                 n_removes++;
        if (r.st == ST_FULL)  n_full_drops++;
        if (r.st == ST_EMPTY) n_empty_rems++;
        @(negedge clk);
    endtask

    // Sender stops and waits until every outstanding result has been seen.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Key mix: small values force major ties, extremes hit the sign boundary.
    function automatic logic signed [KEY_W-1:0] rand_key();
        logic signed [KEY_W-1:0] edges [4];
        edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1};
        case ($urandom_range(3))
            0:       return $urandom_range(6) - 3;
            1:       return edges[$urandom_range(3)];
            default: return $urandom;
        endcase
    endfunction

    // Removes on an empty queue, with keys that must be ignored.
    task automatic test_empty_remove();
        send_request(OP_REMOVE, '1, '1);
    endtask

    // Extreme key pairs, given out of order, then drained and one more empty remove.
    task automatic test_extremes();
        logic signed [KEY_W-1:0] mj [8];
        logic signed [KEY_W-1:0] mn [8];
        mj = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1};
        mn = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1,
               32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 32'sh0};
        foreach (mj[i])
            send_request(OP_INSERT, mj[i], mn[i]);
        repeat (8)
            send_request(OP_REMOVE, $urandom, $urandom);
        send_request(OP_REMOVE, '0, '0);
    endtask

    // Fill to capacity, two dropped inserts, then empty it completely.
    task automatic test_full_queue();
        repeat (CAP)
            send_request(OP_INSERT, rand_key(), rand_key());
        repeat (2)
            send_request(OP_INSERT, rand_key(), rand_key());
        repeat (CAP)
            send_request(OP_REMOVE, $urandom, $urandom);
    endtask

    // Random bursts: fill-heavy, drain-heavy or even, so full and empty both recur.
    task automatic test_random_mix(input int count);
        int sent;
        int burst;
        int ins_pct;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(2))
                0:       ins_pct = 80;
                1:       ins_pct = 20;
                default: ins_pct = 50;
            endcase
            burst = $urandom_range(8, 40);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_request(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                                 rand_key(), rand_key());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: sender mostly busy, receiver stalls about half the time.
        src_idle_pct   = 6;
        sink_stall_pct = 51;
        test_empty_remove();
        test_extremes();
        test_full_queue();
        test_random_mix(500);
        hold_until_drained();

        // Phase 2: the other way round.
        src_idle_pct   = 51;
        sink_stall_pct = 6;
        test_random_mix(500);
        hold_until_drained();

        // Phase 3: back to back, no gaps either side.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_mix(500);
        hold_until_drained();
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("Covered %0d requests: %0d inserts (%0d dropped when full), %0d removes (%0d on empty)",
                 n_inserts + n_removes, n_inserts, n_full_drops, n_removes, n_empty_rems);
        $display("%0d results checked, %0d mismatches, %0d cycles", n_checked, mismatches, cycles);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
